[rtl/perm_eng_pkg.sv]
// Shared types and constants of the permutation engine.
package perm_eng_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int SIZE_W       = IDX_W + 1;

  localparam logic [2:0] OP_LOAD_METHOD = 3'd0;
  localparam logic [2:0] OP_LOAD_PACK   = 3'd1;
  localparam logic [2:0] OP_COMPOSE     = 3'd2;
  localparam logic [2:0] OP_INVERSE     = 3'd3;
  localparam logic [2:0] OP_POWER       = 3'd4;
  localparam logic [2:0] OP_ORDER       = 3'd5;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_METHOD_BAD = 2'd1;
  localparam logic [1:0] ST_PACK_BAD   = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [5:0]         entry_index;
    logic [7:0]         entry_value;
    logic signed [31:0] exponent;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  element;
    logic [5:0]  out_index;
    logic [31:0] order_value;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

endpackage

[rtl/permutation_engine.sv]
// Permutation engine: table loads, permutation check, compose, inverse, power, order.
//
// A transaction is accepted when start is high and busy is low. Load opcodes leave the
// engine idle, so loads may follow each other every cycle. A command first checks its
// tables, then works: compose emits one result per element, inverse builds the deck.
// Power and order walk each cycle of the method permutation through its memory and then
// run a bit-serial remainder unit for each permutation cycle; power then rotates the
// cycle into the deck, order folds the length into a running lcm one multiple at a time.
// Decks are emitted from the work memory. Results appear on out_data for exactly one
// cycle with out_valid high and cannot be held off by the receiver; busy falls in the
// cycle in which the last result of a command is shown. All tables sit in synchronous
// memories with registered reads; unwritten entries read as undefined. perm_size is
// sampled when a command starts; write it only while busy is low.
module permutation_engine (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  perm_eng_pkg::in_item_t  in_data,
  output logic                    out_valid,
  output perm_eng_pkg::out_item_t out_data,
  input  logic                    cfg_we,
  input  logic [6:0]              cfg_wdata
);

  localparam int IW = perm_eng_pkg::IDX_W;
  localparam int SW = perm_eng_pkg::SIZE_W;
  localparam int ME = perm_eng_pkg::MAX_ELEMENTS;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK_RD, S_CHK_EV, S_CMP_RD, S_CMP_PK, S_CMP_OUT,
    S_INV_RD, S_INV_WR, S_SCAN, S_WALK_RD, S_WALK_WR, S_DIV, S_LCM,
    S_ROT_Q, S_ROT_P, S_ROT_WR, S_EMIT_RD, S_EMIT_OUT
  } state_t;

  // memories
  logic [7:0]    method_mem [ME];
  logic [7:0]    pack_mem   [ME];
  logic [6:0]    work_mem   [ME];
  logic [IW-1:0] scratch_mem[ME];
  logic [7:0]    method_rd, pack_rd;
  logic [6:0]    work_rd;
  logic [IW-1:0] scratch_rd;
  logic [IW-1:0] method_ra, pack_ra, scratch_ra, work_wa;
  logic          work_we, scratch_we;
  logic [6:0]    work_wd;

  state_t                  state_r, state_nxt;
  logic [6:0]              perm_size_r, perm_size_nxt;
  logic [2:0]              op_r, op_nxt;
  logic [SW-1:0]           n_r, n_nxt;
  logic [IW-1:0]           nlast_r, nlast_nxt;
  logic                    neg_r, neg_nxt;
  logic [31:0]             mag_r, mag_nxt;
  logic                    chk_pack_r, chk_pack_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic [ME-1:0]           mark_r, mark_nxt;
  logic [IW-1:0]           start_r, start_nxt;
  logic [IW-1:0]           walk_r, walk_nxt;
  logic [SW-1:0]           len_r, len_nxt;
  logic [31:0]             div_q_r, div_q_nxt;
  logic [4:0]              div_cnt_r, div_cnt_nxt;
  logic [SW-1:0]           rem_r, rem_nxt;
  logic [31:0]             lcm_r, lcm_nxt;
  logic [31:0]             m_r, m_nxt;
  logic [SW-1:0]           r_r, r_nxt;
  logic [IW-1:0]           p_r, p_nxt;
  logic [IW-1:0]           q_r, q_nxt;
  logic [IW-1:0]           rotv_r, rotv_nxt;
  logic                    out_valid_r, out_valid_nxt;
  perm_eng_pkg::out_item_t out_r, out_nxt;

  logic          accept, ld_method, ld_pack;
  logic [SW-1:0] n_eff;
  logic [7:0]    chk_v;
  logic [IW-1:0] chk_slot, walk_next;
  logic          chk_bad;
  logic [SW:0]   div_t, div_sub, r_sum;
  logic [SW-1:0] div_rem, r_new, pow_s;
  logic [31:0]   m_sum;

  assign accept    = start && (state_r == S_IDLE);
  assign ld_method = accept && (in_data.opcode == perm_eng_pkg::OP_LOAD_METHOD);
  assign ld_pack   = accept && (in_data.opcode == perm_eng_pkg::OP_LOAD_PACK);

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // clamp the size register into 1..MAX_ELEMENTS
  always_comb begin
    if (perm_size_r == 7'd0) begin
      n_eff = SW'(1);
    end else if (perm_size_r > 7'(ME)) begin
      n_eff = SW'(ME);
    end else begin
      n_eff = SW'(perm_size_r);
    end
  end

  // table check datapath
  assign chk_v    = chk_pack_r ? pack_rd : method_rd;
  assign chk_slot = chk_v[IW-1:0] - IW'(1);
  assign chk_bad  = (chk_v == 8'd0) || (chk_v > 8'(n_r)) || mark_r[chk_slot];

  assign walk_next = method_rd[IW-1:0] - IW'(1);

  // one restoring step of the remainder unit
  assign div_t   = {rem_r, div_q_r[31]};
  assign div_sub = div_t - {1'b0, len_r};
  assign div_rem = (div_t >= {1'b0, len_r}) ? div_sub[SW-1:0] : div_t[SW-1:0];
  assign pow_s   = (neg_r && div_rem != '0) ? (len_r - div_rem) : div_rem;

  // one step of the lcm search
  assign r_sum = {1'b0, r_r} + {1'b0, rem_r};
  assign r_new = (r_sum >= {1'b0, len_r}) ? SW'(r_sum - {1'b0, len_r}) : r_sum[SW-1:0];
  assign m_sum = m_r + lcm_r;

  // memory addressing
  assign method_ra  = (state_r == S_WALK_RD) ? walk_r : idx_r;
  assign pack_ra    = (state_r == S_CMP_PK) ? (method_rd[IW-1:0] - IW'(1)) : idx_r;
  assign scratch_ra = (state_r == S_ROT_Q) ? q_r : p_r;

  always_comb begin
    work_we = 1'b0;
    work_wa = method_rd[IW-1:0] - IW'(1);
    work_wd = 7'(idx_r) + 7'd1;
    if (state_r == S_INV_WR) begin
      work_we = 1'b1;
    end else if (state_r == S_ROT_WR) begin
      work_we = 1'b1;
      work_wa = scratch_rd;
      work_wd = 7'(rotv_r) + 7'd1;
    end
  end
  assign scratch_we = (state_r == S_WALK_WR);

  always_ff @(posedge clk) begin
    if (ld_method) begin
      method_mem[in_data.entry_index] <= in_data.entry_value;
    end
    method_rd <= method_mem[method_ra];
  end

  always_ff @(posedge clk) begin
    if (ld_pack) begin
      pack_mem[in_data.entry_index] <= in_data.entry_value;
    end
    pack_rd <= pack_mem[pack_ra];
  end

  always_ff @(posedge clk) begin
    if (work_we) begin
      work_mem[work_wa] <= work_wd;
    end
    work_rd <= work_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (scratch_we) begin
      scratch_mem[len_r[IW-1:0]] <= walk_r;
    end
    scratch_rd <= scratch_mem[scratch_ra];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    perm_size_nxt = cfg_we ? cfg_wdata : perm_size_r;
    op_nxt        = op_r;
    n_nxt         = n_r;
    nlast_nxt     = nlast_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    chk_pack_nxt  = chk_pack_r;
    idx_nxt       = idx_r;
    mark_nxt      = mark_r;
    start_nxt     = start_r;
    walk_nxt      = walk_r;
    len_nxt       = len_r;
    div_q_nxt     = div_q_r;
    div_cnt_nxt   = div_cnt_r;
    rem_nxt       = rem_r;
    lcm_nxt       = lcm_r;
    m_nxt         = m_r;
    r_nxt         = r_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    rotv_nxt      = rotv_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    case (state_r)
      S_IDLE: begin
        if (accept && in_data.opcode inside {[perm_eng_pkg::OP_COMPOSE:
                                               perm_eng_pkg::OP_ORDER]}) begin
          op_nxt       = in_data.opcode;
          n_nxt        = n_eff;
          nlast_nxt    = IW'(n_eff - SW'(1));
          neg_nxt      = in_data.exponent[31];
          mag_nxt      = in_data.exponent[31] ? (32'd0 - in_data.exponent)
                                              : in_data.exponent;
          chk_pack_nxt = (in_data.opcode == perm_eng_pkg::OP_COMPOSE);
          idx_nxt      = '0;
          mark_nxt     = '0;
          state_nxt    = S_CHK_RD;
        end
      end

      S_CHK_RD: begin
        state_nxt = S_CHK_EV;
      end

      S_CHK_EV: begin
        if (chk_bad) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.status = chk_pack_r ? perm_eng_pkg::ST_PACK_BAD
                                      : perm_eng_pkg::ST_METHOD_BAD;
          out_nxt.last  = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          mark_nxt[chk_slot] = 1'b1;
          idx_nxt            = idx_r + IW'(1);
          state_nxt          = S_CHK_RD;
          if (idx_r == nlast_r) begin
            idx_nxt  = '0;
            mark_nxt = '0;
            if (chk_pack_r) begin
              chk_pack_nxt = 1'b0;
            end else begin
              case (op_r)
                perm_eng_pkg::OP_COMPOSE: state_nxt = S_CMP_RD;
                perm_eng_pkg::OP_INVERSE: state_nxt = S_INV_RD;
                default: begin
                  lcm_nxt   = 32'd1;
                  state_nxt = S_SCAN;
                end
              endcase
            end
          end
        end
      end

      S_CMP_RD:  state_nxt = S_CMP_PK;
      S_CMP_PK:  state_nxt = S_CMP_OUT;
      S_CMP_OUT: begin
        out_valid_nxt     = 1'b1;
        out_nxt           = '0;
        out_nxt.element   = pack_rd[6:0];
        out_nxt.out_index = idx_r;
        out_nxt.last      = (idx_r == nlast_r);
        idx_nxt           = idx_r + IW'(1);
        state_nxt         = (idx_r == nlast_r) ? S_IDLE : S_CMP_RD;
      end

      S_INV_RD: state_nxt = S_INV_WR;
      S_INV_WR: begin
        idx_nxt   = idx_r + IW'(1);
        state_nxt = S_INV_RD;
        if (idx_r == nlast_r) begin
          idx_nxt   = '0;
          state_nxt = S_EMIT_RD;
        end
      end

      S_SCAN: begin
        if (mark_r[idx_r]) begin
          idx_nxt = idx_r + IW'(1);
          if (idx_r == nlast_r) begin
            idx_nxt = '0;
            if (op_r == perm_eng_pkg::OP_ORDER) begin
              out_valid_nxt       = 1'b1;
              out_nxt             = '0;
              out_nxt.order_value = lcm_r;
              out_nxt.last        = 1'b1;
              state_nxt           = S_IDLE;
            end else begin
              state_nxt = S_EMIT_RD;
            end
          end
        end else begin
          start_nxt = idx_r;
          walk_nxt  = idx_r;
          len_nxt   = '0;
          state_nxt = S_WALK_RD;
        end
      end

      S_WALK_RD: state_nxt = S_WALK_WR;
      S_WALK_WR: begin
        mark_nxt[walk_r] = 1'b1;
        len_nxt          = len_r + SW'(1);
        walk_nxt         = walk_next;
        if (walk_next == start_r) begin
          div_q_nxt   = (op_r == perm_eng_pkg::OP_ORDER) ? lcm_r : mag_r;
          div_cnt_nxt = '0;
          rem_nxt     = '0;
          state_nxt   = S_DIV;
        end else begin
          state_nxt = S_WALK_RD;
        end
      end

      S_DIV: begin
        rem_nxt     = div_rem;
        div_q_nxt   = {div_q_r[30:0], 1'b0};
        div_cnt_nxt = div_cnt_r + 5'd1;
        if (div_cnt_r == 5'd31) begin
          if (op_r == perm_eng_pkg::OP_ORDER) begin
            r_nxt     = div_rem;
            m_nxt     = lcm_r;
            state_nxt = (div_rem == '0) ? S_SCAN : S_LCM;
          end else begin
            p_nxt     = '0;
            q_nxt     = pow_s[IW-1:0];
            state_nxt = S_ROT_Q;
          end
        end
      end

      S_LCM: begin
        m_nxt = m_sum;
        r_nxt = r_new;
        if (r_new == '0) begin
          lcm_nxt   = m_sum;
          state_nxt = S_SCAN;
        end
      end

      S_ROT_Q: state_nxt = S_ROT_P;
      S_ROT_P: begin
        rotv_nxt  = scratch_rd;
        state_nxt = S_ROT_WR;
      end
      S_ROT_WR: begin
        p_nxt     = p_r + IW'(1);
        q_nxt     = (SW'(q_r) + SW'(1) == len_r) ? '0 : q_r + IW'(1);
        state_nxt = (SW'(p_r) + SW'(1) == len_r) ? S_SCAN : S_ROT_Q;
      end

      S_EMIT_RD: state_nxt = S_EMIT_OUT;
      S_EMIT_OUT: begin
        out_valid_nxt     = 1'b1;
        out_nxt           = '0;
        out_nxt.element   = work_rd;
        out_nxt.out_index = idx_r;
        out_nxt.last      = (idx_r == nlast_r);
        idx_nxt           = idx_r + IW'(1);
        state_nxt         = (idx_r == nlast_r) ? S_IDLE : S_EMIT_RD;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      perm_size_r <= 7'd64;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      perm_size_r <= perm_size_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    n_r        <= n_nxt;
    nlast_r    <= nlast_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    chk_pack_r <= chk_pack_nxt;
    idx_r      <= idx_nxt;
    mark_r     <= mark_nxt;
    start_r    <= start_nxt;
    walk_r     <= walk_nxt;
    len_r      <= len_nxt;
    div_q_r    <= div_q_nxt;
    div_cnt_r  <= div_cnt_nxt;
    rem_r      <= rem_nxt;
    lcm_r      <= lcm_nxt;
    m_r        <= m_nxt;
    r_r        <= r_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    rotv_r     <= rotv_nxt;
    out_r      <= out_nxt;
  end

endmodule
